@@ design/hjb_pkg.sv @@
// ----------------------------------------------------------------------------
// hjb_pkg: shared types for the hash join build/probe engine
// Item layouts, the internal command format and its operation codes.
// ----------------------------------------------------------------------------
package hjb_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_PROBE = 2'd2;

  localparam logic STATUS_MATCH = 1'b0;
  localparam logic STATUS_DROP  = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [63:0] join_key;
    logic [31:0]        row_number;
    logic [15:0]        chunk_number;
    logic               keep;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] probe_row;
    logic [15:0] probe_chunk;
    logic [31:0] build_row;
    logic [15:0] build_chunk;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_PROBE  = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] key;
    logic [31:0] row;
    logic [15:0] chunk;
  } cmd_t;

  // Handshake between the front queue and the back engine.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

@@ design/hjb_front.sv @@
// ----------------------------------------------------------------------------
// hjb_front: input classifier and command queue
// Turns accepted items into commands, drops filtered ones and the unused mode, queues the rest.
// ----------------------------------------------------------------------------
module hjb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hjb_pkg::in_item_t din,
  input  logic              hold,
  output logic              full,
  output hjb_pkg::cmd_chan_t chan,
  input  logic              cmd_ready
);

  hjb_pkg::cmd_t                q_mem [hjb_pkg::QDEPTH];
  logic [hjb_pkg::QPTR_W-1:0]   wr_ptr;
  logic [hjb_pkg::QPTR_W-1:0]   rd_ptr;
  logic [hjb_pkg::QPTR_W:0]     q_count;
  logic                         accept;
  logic                         store;
  logic                         take;
  hjb_pkg::cmd_t                cmd_in;

  assign full   = hold || (q_count == (hjb_pkg::QPTR_W+1)'(hjb_pkg::QDEPTH));
  assign accept = push && !full;

  // Filtered builds and probes and the unused mode leave no trace.
  always_comb begin
    cmd_in.key   = din.join_key;
    cmd_in.row   = din.row_number;
    cmd_in.chunk = din.chunk_number;
    cmd_in.op    = hjb_pkg::OP_CLEAR;
    store        = 1'b0;
    case (din.mode)
      hjb_pkg::MODE_CLEAR: begin
        store = 1'b1;
      end
      hjb_pkg::MODE_BUILD: begin
        cmd_in.op = hjb_pkg::OP_INSERT;
        store     = din.keep;
      end
      hjb_pkg::MODE_PROBE: begin
        cmd_in.op = hjb_pkg::OP_PROBE;
        store     = din.keep;
      end
      default: store = 1'b0;
    endcase
  end

  assign chan.valid = (q_count != '0);
  assign chan.cmd   = q_mem[rd_ptr];
  assign take       = chan.valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (accept && store) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (accept && store) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + (hjb_pkg::QPTR_W+1)'(accept && store)
                         - (hjb_pkg::QPTR_W+1)'(take);
    end
  end

endmodule

@@ design/hjb_back.sv @@
// ----------------------------------------------------------------------------
// hjb_back: table engine
// Linear probing over one table memory, clearing sweep and result register.
// ----------------------------------------------------------------------------
module hjb_back #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  hjb_pkg::cmd_chan_t  chan,
  output logic                cmd_ready,
  output logic                init_busy,
  output logic                empty,
  input  logic                pop,
  output hjb_pkg::out_item_t  result
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [15:0] chunk;
    logic [31:0] row;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_WALK  = 3'b100
  } state_t;

  entry_t             mem [TABLE_ENTRIES];
  entry_t             rd_q;
  entry_t             wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_en;
  state_t             state;
  state_t             state_next;
  hjb_pkg::cmd_t      cur;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   slot_next;
  logic [IDX_W-1:0]   steps;
  logic               boot;
  logic               out_valid;
  hjb_pkg::out_item_t out_q;
  logic               hit;
  logic               vacant;
  logic               emit;
  hjb_pkg::out_item_t emit_item;

  // Fold the key into the index width, then bring it into table range.
  function automatic logic [IDX_W-1:0] home_slot(input logic [63:0] key);
    logic [IDX_W:0] h;
    h = '0;
    for (int i = 0; i < 64; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ key[i];
    end
    if (h >= (IDX_W+1)'(TABLE_ENTRIES)) begin
      h = h - (IDX_W+1)'(TABLE_ENTRIES);
    end
    return h[IDX_W-1:0];
  endfunction

  assign cmd_ready = (state == S_IDLE) && !out_valid;
  assign init_busy = boot;
  assign empty     = !out_valid;
  assign result    = out_q;

  assign hit       = rd_q.valid && (rd_q.key == cur.key);
  assign vacant    = !rd_q.valid;
  assign slot_next = (slot == LAST_IDX) ? '0 : slot + 1'b1;
  assign rd_addr   = (state == S_IDLE) ? home_slot(chan.cmd.key) : slot_next;

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = slot;
    wr_data    = '{valid: 1'b1, key: cur.key, chunk: cur.chunk, row: cur.row};
    emit       = 1'b0;
    emit_item  = '{status: hjb_pkg::STATUS_MATCH, probe_row: cur.row,
                   probe_chunk: cur.chunk, build_row: rd_q.row,
                   build_chunk: rd_q.chunk};
    case (state)
      S_CLEAR: begin
        wr_en         = 1'b1;
        wr_data.valid = 1'b0;
        if (slot == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (chan.valid && cmd_ready) begin
          state_next = (chan.cmd.op == hjb_pkg::OP_CLEAR) ? S_CLEAR : S_WALK;
        end
      end
      S_WALK: begin
        if (hit || vacant) begin
          state_next = S_IDLE;
          if (cur.op == hjb_pkg::OP_INSERT) begin
            wr_en = 1'b1;
          end else begin
            emit = hit;
          end
        end else if (steps == LAST_IDX) begin
          // Every slot holds another key.
          state_next = S_IDLE;
          if (cur.op == hjb_pkg::OP_INSERT) begin
            emit      = 1'b1;
            emit_item = '{status: hjb_pkg::STATUS_DROP, probe_row: cur.row,
                          probe_chunk: cur.chunk, build_row: '0, build_chunk: '0};
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (emit) begin
      out_q <= emit_item;
    end
    if (state == S_IDLE) begin
      cur <= chan.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      slot      <= '0;
      steps     <= '0;
      boot      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: begin
          slot <= slot_next;
          if (slot == LAST_IDX) begin
            boot <= 1'b0;
          end
        end
        S_IDLE: begin
          steps <= '0;
          if (chan.valid && cmd_ready) begin
            if (chan.cmd.op == hjb_pkg::OP_CLEAR) begin
              slot <= '0;
            end else begin
              slot <= rd_addr;
            end
          end
        end
        S_WALK: begin
          slot  <= slot_next;
          steps <= steps + 1'b1;
        end
        default: slot <= '0;
      endcase
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/hash_join_build_probe.sv @@
// ----------------------------------------------------------------------------
// hash_join_build_probe: equi-join build/probe engine on 64-bit keys
// Keeps a table of keys with row and chunk numbers and reports probe matches.
// ----------------------------------------------------------------------------
// Items enter through a queue port (push/full) and results leave through a
// queue port (empty/pop). A clear item empties the table, a kept build item
// stores or overwrites its key, a kept probe item reports a match, and a build
// of a new key into a full table reports a drop. Filtered items give nothing.
// Accepted items wait in a four-entry command queue, so input is taken while
// a result waits to be popped. The engine handles one command at a time from
// one table memory: a lookup or insert walks its home slot and then one
// collision slot after another (up to TABLE_ENTRIES slots in all), and its
// result is on the result ports as soon as the walk ends.
// A clear sweeps every slot of the table.
// After reset the same sweep runs, with full held high.
// While the result is not popped the engine takes no new command; the queue
// keeps accepting until it fills.
// ----------------------------------------------------------------------------
module hash_join_build_probe #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hjb_pkg::in_item_t  din,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output hjb_pkg::out_item_t result
);

  hjb_pkg::cmd_chan_t chan;
  logic               cmd_ready;
  logic               init_busy;

  hjb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (din),
    .hold      (init_busy),
    .full      (full),
    .chan      (chan),
    .cmd_ready (cmd_ready)
  );

  hjb_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .chan      (chan),
    .cmd_ready (cmd_ready),
    .init_busy (init_busy),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // The input side is closed right after reset, as the sweep begins.
  a_boot_full: assert property (@(posedge clk) $past(rst) |-> full)
    else $error("input open right after reset");

  // A command is taken only when no result is waiting.
  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    (chan.valid && cmd_ready) |-> empty)
    else $error("command taken while a result waits");

  // No result appears right after a command is taken; results come from a walk.
  a_emit_walk: assert property (@(posedge clk) disable iff (rst)
    (chan.valid && cmd_ready) |=> empty)
    else $error("result appeared on command take");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the hash join build/probe engine
// Drives clear, build and probe items through the input queue and checks every
// matched pair and table-full drop against an in-bench model of the key table.
// ----------------------------------------------------------------------------
module tb;

  localparam int          TABLE_SIZE  = 4096;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int          STUCK_LIMIT = 60000;
  localparam int          TAIL_CYCLES = 2 * TABLE_SIZE + 100;
  localparam int          PHASE_ITEMS = 430;

  // Mirrors the key table: stored payload per key plus the number of entries.
  class join_predictor;
    bit [47:0]          stored [bit [63:0]];
    int unsigned        live;
    hjb_pkg::out_item_t pending_pairs [$];
    int                 mismatches;

    function void note_item(hjb_pkg::in_item_t it);
      hjb_pkg::out_item_t exp;
      bit [63:0] k;
      k = it.join_key;
      exp = '0;
      if (it.mode == hjb_pkg::MODE_CLEAR) begin
        stored.delete();
        live = 0;
        return;
      end
      if (!it.keep) return;
      if (it.mode == hjb_pkg::MODE_BUILD) begin
        if (stored.exists(k)) begin
          stored[k] = {it.chunk_number, it.row_number};
        end else if (live >= TABLE_SIZE) begin
          exp.status = hjb_pkg::STATUS_DROP;
          exp.probe_row = it.row_number;
          exp.probe_chunk = it.chunk_number;
          pending_pairs = {pending_pairs, exp};
        end else begin
          stored[k] = {it.chunk_number, it.row_number};
          live++;
        end
      end else if (it.mode == hjb_pkg::MODE_PROBE && stored.exists(k)) begin
        exp.status = hjb_pkg::STATUS_MATCH;
        exp.probe_row = it.row_number;
        exp.probe_chunk = it.chunk_number;
        exp.build_row = stored[k][31:0];
        exp.build_chunk = stored[k][47:32];
        pending_pairs = {pending_pairs, exp};
      end
    endfunction

    function void check_pair(hjb_pkg::out_item_t got);
      hjb_pkg::out_item_t exp;
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending_pairs.pop_front();
      if (got.status !== exp.status || got.probe_row !== exp.probe_row ||
          got.probe_chunk !== exp.probe_chunk || got.build_row !== exp.build_row ||
          got.build_chunk !== exp.build_chunk) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               push;
  hjb_pkg::in_item_t  din;
  logic               full;
  logic               empty;
  logic               pop;
  hjb_pkg::out_item_t result;

  join_predictor model;
  int        send_idle;
  int        recv_idle;
  bit        hold_req;
  int        hold_left;
  int        stuck;
  bit [63:0] key_pool [24];

  hash_join_build_probe #(.TABLE_ENTRIES(TABLE_SIZE)) dut (
    .clk(clk), .rst(rst), .push(push), .din(din), .full(full),
    .empty(empty), .pop(pop), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: pops at random, or holds off for a long stretch on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) model.check_pair(result);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // Entered and left at a falling edge.
  task automatic send_item(hjb_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    din <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    model.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] mode, bit [63:0] k, bit [31:0] row,
                             bit [15:0] chunk, bit keep);
    hjb_pkg::in_item_t it;
    it.mode = mode;
    it.join_key = k;
    it.row_number = row;
    it.chunk_number = chunk;
    it.keep = keep;
    send_item(it);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(negedge clk);
    while (model.pending_pairs.size() != 0) @(negedge clk);
  endtask

  function automatic hjb_pkg::in_item_t random_item();
    hjb_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 3)       it.mode = hjb_pkg::MODE_CLEAR;
    else if (pick < 45) it.mode = hjb_pkg::MODE_BUILD;
    else if (pick < 96) it.mode = hjb_pkg::MODE_PROBE;
    else                it.mode = MODE_UNUSED;
    if ($urandom_range(99) < 75) it.join_key = key_pool[$urandom_range(23)];
    else                         it.join_key = {$urandom, $urandom};
    it.row_number = $urandom;
    it.chunk_number = 16'($urandom_range(16'hFFFF));
    it.keep = ($urandom_range(99) >= 10);
    return it;
  endfunction

  initial begin
    model = new();
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    din = '0;
    hold_req = 1'b0;
    hold_left = 0;
    stuck = 0;
    send_idle = 36;
    recv_idle = 47;
    key_pool[0] = 64'h0;
    key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_pool[2] = 64'h7FFF_FFFF_FFFF_FFFF;
    key_pool[3] = 64'h8000_0000_0000_0000;
    for (int i = 4; i < 24; i++) key_pool[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extreme keys and fields, overwrite, filtering, misses, unused mode, clear.
    send_fields(hjb_pkg::MODE_BUILD, key_pool[0], 32'h0, 16'h0, 1'b1);
    send_fields(hjb_pkg::MODE_BUILD, key_pool[1], 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_fields(hjb_pkg::MODE_BUILD, key_pool[2], 32'h1234_5678, 16'h00FF, 1'b1);
    send_fields(hjb_pkg::MODE_BUILD, key_pool[3], 32'h8000_0001, 16'h8000, 1'b1);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[0], 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[1], 32'h0, 16'h0, 1'b1);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[2], 32'h5, 16'h6, 1'b1);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[3], 32'h7, 16'h8, 1'b1);
    send_fields(hjb_pkg::MODE_BUILD, key_pool[0], 32'hAAAA_5555, 16'h5A5A, 1'b1);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[0], 32'h9, 16'h1, 1'b1);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[4], 32'h2, 16'h2, 1'b1);
    send_fields(hjb_pkg::MODE_BUILD, key_pool[4], 32'h3, 16'h3, 1'b0);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[4], 32'h4, 16'h4, 1'b1);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[1], 32'h4, 16'h4, 1'b0);
    send_fields(MODE_UNUSED, key_pool[1], 32'h4, 16'h4, 1'b1);
    send_fields(hjb_pkg::MODE_CLEAR, key_pool[1], 32'h0, 16'h0, 1'b0);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[0], 32'h1, 16'h1, 1'b1);
    send_fields(hjb_pkg::MODE_PROBE, key_pool[1], 32'h1, 16'h1, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 36 : (phase == 1) ? 47 : 0;
      recv_idle = (phase == 0) ? 47 : (phase == 1) ? 36 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 100) hold_req = 1'b1;
        if (phase == 1 && n == 200) drain_results();
        send_item(random_item());
      end
    end

    send_fields(hjb_pkg::MODE_CLEAR, 64'h0, 32'h0, 16'h0, 1'b1);
    for (int n = 0; n < 40; n++) send_item(random_item());

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (model.mismatches == 0 && model.pending_pairs.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
